// ----- src/sine_taylor_series_macros.svh -----
// assertion macros for the sine taylor series block
`ifndef SINE_TAYLOR_SERIES_MACROS_SVH
`define SINE_TAYLOR_SERIES_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define STS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sine taylor series check failed");

// next-cycle implication, checked out of reset
`define STS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sine taylor series check failed");

`else

`define STS_ASSERT_IMP(lbl, ante, cons)
`define STS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- src/sts_pkg.sv -----
// shared widths, constants, types and reciprocal table of the sine series
package sts_pkg;

  localparam int MAX_TERMS_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int Q_FRAC = 30;
  localparam int A_W    = 33;
  localparam int X_W    = 31;
  localparam int X2_W   = 32;
  localparam int P_W    = 32;
  localparam int TERM_W = 31;
  localparam int RCP_W  = 28;
  localparam int SUM_W  = 33;
  localparam int MAG_W  = 31;
  localparam int LAST_W = 3;

  localparam logic [LAST_W-1:0] HIGHEST_TERM_RST = 3'd7;

  localparam logic [A_W-1:0] Q30_HALF_PI       = 33'd1686629713;
  localparam logic [A_W-1:0] Q30_PI            = 33'd3373259426;
  localparam logic [A_W-1:0] Q30_THREE_HALF_PI = 33'd5059889139;
  localparam logic [A_W-1:0] Q30_TWO_PI        = 33'd6746518852;
  localparam logic [MAG_W-1:0] Q30_ONE         = 31'd1073741824;

  typedef struct packed {
    logic valid;
    logic neg;
  } sts_ctl_t;

  // 1/((2i)(2i+1)) in q.30, rounded to nearest
  function automatic logic [RCP_W-1:0] sts_recip(input int idx);
    logic [RCP_W-1:0] r;
    unique case (idx)
      1:       r = 28'd178956971;
      2:       r = 28'd53687091;
      3:       r = 28'd25565282;
      4:       r = 28'd14913081;
      5:       r = 28'd9761289;
      6:       r = 28'd6882960;
      7:       r = 28'd5113056;
      8:       r = 28'd3947580;
      9:       r = 28'd3139596;
      10:      r = 28'd2556528;
      11:      r = 28'd2122019;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/sts_front.sv -----
// angle wrap, quadrant fold and squaring stages ahead of the series cells
module sts_front #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FRAC_BITS+2:0]     in_angle_rad,
  output sts_pkg::sts_ctl_t        dn_ctl,
  output logic [sts_pkg::X2_W-1:0] dn_x2,
  output logic [sts_pkg::TERM_W-1:0] dn_term,
  input  logic                     dn_ready
);
  import sts_pkg::*;

  localparam int SH = Q_FRAC - FRAC_BITS;

  logic           w_valid_r, f_valid_r, s_valid_r;
  logic           w_en, f_en, s_en;
  logic [A_W-1:0] a_in;
  logic [A_W-1:0] wa_r, wa_nxt;
  logic [X_W-1:0] fx_r, fx_nxt;
  logic           fneg_r, fneg_nxt;
  logic [X_W-1:0] sx_r;
  logic           sneg_r;
  logic [X2_W-1:0] x2_r;
  logic [2*X_W-1:0] sq;

  // stage enables ripple back from the cells
  assign s_en     = !s_valid_r || dn_ready;
  assign f_en     = !f_valid_r || s_en;
  assign w_en     = !w_valid_r || f_en;
  assign in_stall = !w_en;

  // wrap once below two pi
  assign a_in   = A_W'(in_angle_rad) << SH;
  assign wa_nxt = (a_in >= Q30_TWO_PI) ? (a_in - Q30_TWO_PI) : a_in;

  // fold into the first quadrant
  always_comb begin
    priority if (wa_r < Q30_HALF_PI) begin
      fx_nxt   = X_W'(wa_r);
      fneg_nxt = 1'b0;
    end else if (wa_r < Q30_PI) begin
      fx_nxt   = X_W'(Q30_PI - wa_r);
      fneg_nxt = 1'b0;
    end else if (wa_r < Q30_THREE_HALF_PI) begin
      fx_nxt   = X_W'(wa_r - Q30_PI);
      fneg_nxt = 1'b1;
    end else begin
      fx_nxt   = X_W'(Q30_TWO_PI - wa_r);
      fneg_nxt = 1'b1;
    end
  end

  assign sq = (2*X_W)'(fx_r) * (2*X_W)'(fx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      if (w_en) w_valid_r <= in_valid;
      if (f_en) f_valid_r <= w_valid_r;
      if (s_en) s_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) wa_r <= wa_nxt;
    if (f_en) begin
      fx_r   <= fx_nxt;
      fneg_r <= fneg_nxt;
    end
    if (s_en) begin
      sx_r   <= fx_r;
      sneg_r <= fneg_r;
      x2_r   <= sq[2*Q_FRAC+1:Q_FRAC];
    end
  end

  assign dn_ctl  = '{valid: s_valid_r, neg: sneg_r};
  assign dn_x2   = x2_r;
  assign dn_term = sx_r;

endmodule

// ----- src/sts_cell.sv -----
// one series cell: folds in the previous term and forms the next one
module sts_cell #(
  parameter int IDX = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sts_pkg::LAST_W-1:0] last_term,
  input  sts_pkg::sts_ctl_t          up_ctl,
  input  logic [sts_pkg::X2_W-1:0]   up_x2,
  input  logic [sts_pkg::TERM_W-1:0] up_term,
  input  logic signed [sts_pkg::SUM_W-1:0] up_sum,
  output logic                       up_ready,
  output sts_pkg::sts_ctl_t          dn_ctl,
  output logic [sts_pkg::X2_W-1:0]   dn_x2,
  output logic [sts_pkg::TERM_W-1:0] dn_term,
  output logic signed [sts_pkg::SUM_W-1:0] dn_sum,
  input  logic                       dn_ready
);
  import sts_pkg::*;

  localparam logic [RCP_W-1:0] RCP = sts_recip(IDX);
  localparam bit PREV_SUB = ((IDX - 1) % 2) == 1;

  logic                    en1, en2;
  sts_ctl_t                ctl1_r, ctl2_r;
  logic [X2_W-1:0]         x2_1_r, x2_2_r;
  logic [P_W-1:0]          p_r;
  logic [TERM_W-1:0]       term_r;
  logic signed [SUM_W-1:0] sum1_r, sum2_r, sum1_nxt, delta;
  logic                    incl;
  logic [2*P_W-3:0]        prod1;
  logic [P_W+RCP_W-1:0]    prod2;

  assign en2      = !ctl2_r.valid || dn_ready;
  assign en1      = !ctl1_r.valid || en2;
  assign up_ready = en1;

  // previous term is summed only if it is within the configured count
  assign incl     = (IDX - 1) <= int'(last_term);
  assign delta    = $signed({2'b00, up_term});
  assign sum1_nxt = !incl ? up_sum : (PREV_SUB ? (up_sum - delta) : (up_sum + delta));

  assign prod1 = (2*P_W-2)'(up_term) * (2*P_W-2)'(up_x2);
  assign prod2 = (P_W+RCP_W)'(p_r) * (P_W+RCP_W)'(RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      if (en1) ctl1_r <= up_ctl;
      if (en2) ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x2_1_r     <= up_x2;
      p_r        <= prod1[Q_FRAC+P_W-1:Q_FRAC];
      sum1_r     <= sum1_nxt;
    end
    if (en2) begin
      x2_2_r     <= x2_1_r;
      term_r     <= TERM_W'(prod2[P_W+RCP_W-1:Q_FRAC]);
      sum2_r     <= sum1_r;
    end
  end

  assign dn_ctl  = ctl2_r;
  assign dn_x2   = x2_2_r;
  assign dn_term = term_r;
  assign dn_sum  = sum2_r;

endmodule

// ----- src/sts_tail.sv -----
// last term, clamp, rounding and signed output register
module sts_tail #(
  parameter int TERM_IDX  = sts_pkg::MAX_TERMS_DEF - 1,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sts_pkg::LAST_W-1:0] last_term,
  input  sts_pkg::sts_ctl_t          up_ctl,
  input  logic [sts_pkg::TERM_W-1:0] up_term,
  input  logic signed [sts_pkg::SUM_W-1:0] up_sum,
  output logic                       up_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [FRAC_BITS+1:0] out_sine_value
);
  import sts_pkg::*;

  localparam int SH    = Q_FRAC - FRAC_BITS;
  localparam int RM_W  = FRAC_BITS + 1;
  localparam int OUT_W = FRAC_BITS + 2;
  localparam logic [MAG_W:0] RND_HALF = ((MAG_W+1)'(1) << SH) >> 1;
  localparam logic [RM_W-1:0] RM_ONE  = RM_W'(1) << FRAC_BITS;
  localparam bit LAST_SUB = (TERM_IDX % 2) == 1;

  logic                    en_c, en_r, en_o;
  sts_ctl_t                ctl_c_r, ctl_r_r;
  logic                    out_valid_r;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [RM_W-1:0]         rmag_r, rmag_nxt;
  logic [MAG_W:0]          rnd_sum;
  logic signed [OUT_W-1:0] sine_r, sine_nxt;
  logic signed [SUM_W-1:0] sum_f, delta;
  logic                    incl;

  assign en_o     = !out_valid_r || !out_stall;
  assign en_r     = !ctl_r_r.valid || en_o;
  assign en_c     = !ctl_c_r.valid || en_r;
  assign up_ready = en_c;

  assign incl  = TERM_IDX <= int'(last_term);
  assign delta = $signed({2'b00, up_term});
  assign sum_f = !incl ? up_sum : (LAST_SUB ? (up_sum - delta) : (up_sum + delta));

  // clamp to [0, one]
  always_comb begin
    priority if (sum_f < 0) begin
      mag_nxt = '0;
    end else if (sum_f > $signed({2'b00, Q30_ONE})) begin
      mag_nxt = Q30_ONE;
    end else begin
      mag_nxt = MAG_W'(sum_f);
    end
  end

  // round half up to the output precision
  assign rnd_sum  = {1'b0, mag_r} + RND_HALF;
  assign rmag_nxt = (rnd_sum[SH +: RM_W] > RM_ONE) ? RM_ONE : rnd_sum[SH +: RM_W];

  assign sine_nxt = ctl_r_r.neg ? ($signed(OUT_W'(0)) - $signed({1'b0, rmag_r}))
                                : $signed({1'b0, rmag_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r     <= '0;
      ctl_r_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_c) ctl_c_r     <= up_ctl;
      if (en_r) ctl_r_r     <= ctl_c_r;
      if (en_o) out_valid_r <= ctl_r_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) mag_r  <= mag_nxt;
    if (en_r) rmag_r <= rmag_nxt;
    if (en_o) sine_r <= sine_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = sine_r;

endmodule

// ----- src/sine_taylor_series.sv -----
// top level of the pipelined taylor series sine
// sine of an angle in radians, given as unsigned q3.FRAC_BITS in [0, 8), returned as
// signed q1.FRAC_BITS saturated to plus or minus one. the angle is wrapped once below
// two pi, folded into [0, pi/2] by quadrant, and the alternating series
// x - x^3/3! + x^5/5! - ... is summed in q.30 up to and including the term of index
// cfg_highest_term (limited to MAX_TERMS-1; reset value 7). one transaction is taken
// per clock while in_stall is low; each result passes through three front stages
// (wrap, fold, square), two stages per series cell (one multiply each), and three
// tail stages (last term and clamp, rounding, sign and output register). every stage
// stalls only when it is full and the one after it cannot take its data, so bubbles
// are squeezed out under a stalled output. cfg_highest_term is to be written only
// while no transaction is in flight.
module sine_taylor_series #(
  parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [sts_pkg::LAST_W-1:0] cfg_highest_term,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FRAC_BITS+2:0]       in_angle_rad,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [FRAC_BITS+1:0] out_sine_value
);
  import sts_pkg::*;

  `include "sine_taylor_series_macros.svh"

  // number of series cells, one per term after the first
  localparam int NC       = MAX_TERMS - 1;
  localparam int LAST_CAP = MAX_TERMS - 1;
  localparam int OUT_W    = FRAC_BITS + 2;
  localparam logic signed [OUT_W-1:0] SINE_POS_ONE = OUT_W'(1) << FRAC_BITS;
  localparam logic signed [OUT_W-1:0] SINE_NEG_ONE = -(OUT_W'(1) << FRAC_BITS);

  logic [LAST_W-1:0] highest_term_r;
  logic [LAST_W-1:0] last_term;

  // chain links: index k is what feeds cell k+1 (or the tail for k == NC)
  sts_ctl_t                chain_ctl  [0:NC];
  logic [X2_W-1:0]         chain_x2   [0:NC];
  logic [TERM_W-1:0]       chain_term [0:NC];
  logic signed [SUM_W-1:0] chain_sum  [0:NC];
  logic                    chain_rdy  [0:NC];

  // configuration register, plain write with no handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_term_r <= HIGHEST_TERM_RST;
    end else if (cfg_wr_en) begin
      highest_term_r <= cfg_highest_term;
    end
  end

  // limit the term index to the cells that exist
  assign last_term = (int'(highest_term_r) > LAST_CAP) ? LAST_W'(LAST_CAP) : highest_term_r;

  sts_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_angle_rad (in_angle_rad),
    .dn_ctl       (chain_ctl[0]),
    .dn_x2        (chain_x2[0]),
    .dn_term      (chain_term[0]),
    .dn_ready     (chain_rdy[0])
  );

  // term zero is x itself and nothing has been summed yet
  assign chain_sum[0] = '0;

  // series cells, each multiplying the running term by x^2 and its reciprocal
  for (genvar k = 1; k <= NC; k++) begin : g_cell
    sts_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .last_term (last_term),
      .up_ctl    (chain_ctl[k-1]),
      .up_x2     (chain_x2[k-1]),
      .up_term   (chain_term[k-1]),
      .up_sum    (chain_sum[k-1]),
      .up_ready  (chain_rdy[k-1]),
      .dn_ctl    (chain_ctl[k]),
      .dn_x2     (chain_x2[k]),
      .dn_term   (chain_term[k]),
      .dn_sum    (chain_sum[k]),
      .dn_ready  (chain_rdy[k])
    );
  end

  // the tail adds the last pending term, clamps, rounds and applies the sign
  sts_tail #(
    .TERM_IDX  (NC),
    .FRAC_BITS (FRAC_BITS)
  ) u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .last_term      (last_term),
    .up_ctl         (chain_ctl[NC]),
    .up_term        (chain_term[NC]),
    .up_sum         (chain_sum[NC]),
    .up_ready       (chain_rdy[NC]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sine_value (out_sine_value)
  );

  // an empty output register lets the whole chain advance
  `STS_ASSERT_IMP(a_ready_when_out_empty, !out_valid, !in_stall)
  // results never leave the unit circle
  `STS_ASSERT_IMP(a_sine_in_range, out_valid,
                  (out_sine_value <= SINE_POS_ONE) && (out_sine_value >= SINE_NEG_ONE))
  // the term limit never exceeds the cells that exist
  `STS_ASSERT_NXT(a_last_term_capped, 1'b1, int'(last_term) <= LAST_CAP)

endmodule

// ----- test/tb_sine_taylor_series.sv -----
// self-checking testbench for the pipelined taylor series sine
`timescale 1ns / 100ps

module tb_sine_taylor_series;

  // runaway guard, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 25;

  // q3.16 grid points closest to the quadrant edges, and the widest angle
  localparam int ANG_HALF_PI = 102944;
  localparam int ANG_PI = 205887;
  localparam int ANG_THREE_HALF_PI = 308831;
  localparam int ANG_TWO_PI = 411775;
  localparam int ANG_MAX = 524287;

  // term count per phase, both extremes and every value in between
  localparam logic [2:0] PHASE_TERMS [NUM_PHASES] = '{
    3'd7, 3'd0, 3'd3, 3'd6, 3'd1, 3'd4, 3'd2, 3'd5
  };

  // edge angles run with the full series: zero, each quadrant boundary from
  // both sides, the wrap at two pi, the widest input and single high bits
  localparam logic [18:0] EDGE_ANGLES [18] = '{
    19'd0, 19'd1, 19'd51472, 19'd102943, 19'd102944, 19'd205887,
    19'd205888, 19'd308831, 19'd308832, 19'd411774, 19'd411775,
    19'd411776, 19'd524287, 19'd262144, 19'd262143, 19'd65536,
    19'd131072, 19'd450000
  };

  // angles run with one term only: saturation on both signs, tiny x
  localparam logic [18:0] ONE_TERM_ANGLES [6] = '{
    19'd102943, 19'd308831, 19'd80000, 19'd250000, 19'd1, 19'd411774
  };

  // holds the expected sines in acceptance order and checks results
  class sine_scoreboard;
    logic [2:0] term_idx;
    logic signed [17:0] expected_sines[$];
    int errors;
    int reported;

    function new();
      term_idx = sts_pkg::HIGHEST_TERM_RST;
      errors = 0;
      reported = 0;
    endfunction

    function void set_term(logic [2:0] t);
      term_idx = t;
    endfunction

    // 1/((2i)(2i+1)) in q.30, rounded to nearest
    function longint unsigned inv_pair(int i);
      case (i)
        1: return 64'd178956971;
        2: return 64'd53687091;
        3: return 64'd25565282;
        4: return 64'd14913081;
        5: return 64'd9761289;
        6: return 64'd6882960;
        7: return 64'd5113056;
        default: return 64'd0;
      endcase
    endfunction

    // bit-exact sine of one angle at the current term count
    function logic signed [17:0] taylor_sine(logic [18:0] ang);
      longint unsigned a, x, x2, term, mag;
      longint sum;
      bit neg;
      int last;
      logic [17:0] res;
      a = longint'(ang) << 14;
      neg = 1'b0;
      // one wrap is enough, the widest input stays below four pi
      if (a >= sts_pkg::Q30_TWO_PI) a = a - sts_pkg::Q30_TWO_PI;
      // fold into [0, pi/2], the lower half-turn stays positive
      if (a < sts_pkg::Q30_HALF_PI) begin
        x = a;
      end else if (a < sts_pkg::Q30_PI) begin
        x = sts_pkg::Q30_PI - a;
      end else if (a < sts_pkg::Q30_THREE_HALF_PI) begin
        x = a - sts_pkg::Q30_PI;
        neg = 1'b1;
      end else begin
        x = sts_pkg::Q30_TWO_PI - a;
        neg = 1'b1;
      end
      last = int'(term_idx);
      if (last > sts_pkg::MAX_TERMS_DEF - 1) last = sts_pkg::MAX_TERMS_DEF - 1;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= last; i++) begin
        term = (term * x2) >> 30;
        term = (term * inv_pair(i)) >> 30;
        if (i % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      // clamp to [0, 1] in q.30, a lone x term can pass one
      if (sum < 0) sum = 0;
      if (sum > longint'(sts_pkg::Q30_ONE)) sum = longint'(sts_pkg::Q30_ONE);
      // round half up to 16 fraction bits, then saturate
      mag = (longint'(sum) + 64'd8192) >> 14;
      if (mag > 64'd65536) mag = 64'd65536;
      // zero magnitude stays zero in a negative quadrant
      res = neg ? (18'd0 - mag[17:0]) : mag[17:0];
      return signed'(res);
    endfunction

    function void note_angle(logic [18:0] ang);
      expected_sines.push_back(taylor_sine(ang));
    endfunction

    function void check_sine(logic signed [17:0] got);
      logic signed [17:0] want;
      if (expected_sines.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected sine %0d with no angle pending", got);
        end
      end else begin
        want = expected_sines.pop_front();
        if (got !== want) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("sine mismatch: expected %0d, got %0d", want, got);
          end
        end
      end
    endfunction

    function int pending();
      return expected_sines.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [sts_pkg::LAST_W-1:0] cfg_highest_term = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [18:0] in_angle_rad = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] out_sine_value;

  sine_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // main process bumps hold_asks, the receiver answers each with one long hold
  int hold_asks = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  sine_taylor_series uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_highest_term (cfg_highest_term),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle_rad     (in_angle_rad),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_value   (out_sine_value)
  );

  always #1 clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_asks != holds_done) begin
      holds_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor, values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_sine(out_sine_value);
  end

  // register write, only called with nothing in flight
  task automatic set_term(input logic [2:0] t);
    cfg_wr_en <= 1'b1;
    cfg_highest_term <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_term(t);
  endtask

  // offer one angle after a random gap, hold it until it is accepted
  task automatic send_angle(input logic [18:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_rad <= ang;
    do @(posedge clk); while (in_stall);
    sb.note_angle(ang);
  endtask

  // mostly in-range angles, with quadrant edges, wrapped and tiny ones mixed in
  function automatic logic [18:0] pick_angle();
    int sel;
    int base;
    sel = $urandom_range(99);
    if (sel < 60) return 19'($urandom_range(ANG_TWO_PI - 1));
    if (sel < 80) begin
      case ($urandom_range(4))
        0: base = 0;
        1: base = ANG_HALF_PI;
        2: base = ANG_PI;
        3: base = ANG_THREE_HALF_PI;
        default: base = ANG_TWO_PI;
      endcase
      base = base + int'($urandom_range(64)) - 32;
      if (base < 0) base = 0;
      return 19'(base);
    end
    if (sel < 90) return 19'($urandom_range(ANG_MAX, ANG_TWO_PI));
    if (sel < 95) return 19'($urandom_range(255));
    return 19'($urandom);
  endfunction

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      // receiver sparse first, then sender sparse, then full rate
      if (p < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 77;
      end else if (p < 6) begin
        send_idle_pct = 77;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_term(PHASE_TERMS[p]);
      if (p == 0) begin
        foreach (EDGE_ANGLES[k]) send_angle(EDGE_ANGLES[k]);
      end
      if (p == 1) begin
        foreach (ONE_TERM_ANGLES[k]) send_angle(ONE_TERM_ANGLES[k]);
      end
      // long output hold while angles keep coming, fills the pipe
      if (p == 6) hold_asks = hold_asks + 1;
      repeat (ITEMS_PER_PHASE) send_angle(pick_angle());
      in_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sine_taylor_series.f -----
+incdir+src
src/sts_pkg.sv
src/sts_front.sv
src/sts_cell.sv
src/sts_tail.sv
src/sine_taylor_series.sv
test/tb_sine_taylor_series.sv
